// ----- design/socd_two_key_toggle_filter_core_assert.svh -----
// Assertion macros for the SOCD two-key toggle filter.
// Used by the queue and the back end; depends on nothing.
`ifndef SOCD_TWO_KEY_TOGGLE_FILTER_CORE_ASSERT_SVH
`define SOCD_TWO_KEY_TOGGLE_FILTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SOCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SOCD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SOCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SOCD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/socd_ttf_pkg.sv -----
// Shared types and constants of the SOCD two-key toggle filter.
// No dependencies.
package socd_ttf_pkg;

  localparam int unsigned KeyW = 10;

  localparam logic [15:0] TypeSync = 16'd0;
  localparam logic [15:0] TypeKey  = 16'd1;
  localparam logic [15:0] TypeMisc = 16'd4;
  localparam logic [15:0] CodeScan = 16'd4;

  localparam logic [1:0] CfgFirstKey     = 2'd0;
  localparam logic [1:0] CfgSecondKey    = 2'd1;
  localparam logic [1:0] CfgFirstVirtual = 2'd2;
  localparam logic [1:0] CfgSecondVirt   = 2'd3;

  localparam logic [KeyW-1:0] RstFirstKey     = 10'd44;
  localparam logic [KeyW-1:0] RstSecondKey    = 10'd45;
  localparam logic [KeyW-1:0] RstFirstVirtual = 10'd183;
  localparam logic [KeyW-1:0] RstSecondVirt   = 10'd184;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  typedef enum logic [1:0] {
    CmdPass    = 2'd0,
    CmdPress   = 2'd1,
    CmdSwap    = 2'd2,
    CmdRelease = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e       kind;
    logic [15:0]     ev_type;
    logic [15:0]     code;
    logic [KeyW-1:0] alt;
    logic [31:0]     value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_push_t;

endpackage

// ----- design/socd_ttf_front.sv -----
// Front end: configuration registers, per-device key state and event
// classification into commands. Depends on socd_ttf_pkg.
module socd_ttf_front #(
  parameter int unsigned MaxDevices = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [9:0]             cfg_wdata_i,
  input  logic                   accept_i,
  input  logic [1:0]             source_device_i,
  input  logic [15:0]            event_type_i,
  input  logic [15:0]            event_code_i,
  input  logic signed [31:0]     event_value_i,
  output socd_ttf_pkg::q_push_t  push_o
);
  import socd_ttf_pkg::*;

  localparam int unsigned DevW = (MaxDevices > 1) ? $clog2(MaxDevices) : 1;

  logic [KeyW-1:0] first_key_q, second_key_q, first_virt_q, second_virt_q;
  logic [MaxDevices-1:0] first_held_q, second_held_q, active_q;

  logic            is_scan, is_first, is_second, is_pass, val_ok, dev_ok, upd;
  logic [DevW-1:0] idx;
  logic            v, hf_new, hs_new, act, act_new;
  logic [1:0]      n;
  logic [KeyW-1:0] up, down;
  cmd_t            cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_key_q   <= RstFirstKey;
      second_key_q  <= RstSecondKey;
      first_virt_q  <= RstFirstVirtual;
      second_virt_q <= RstSecondVirt;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFirstKey:     first_key_q   <= cfg_wdata_i;
        CfgSecondKey:    second_key_q  <= cfg_wdata_i;
        CfgFirstVirtual: first_virt_q  <= cfg_wdata_i;
        CfgSecondVirt:   second_virt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_scan   = (event_type_i == TypeMisc) && (event_code_i == CodeScan);
    is_first  = (event_code_i == 16'(first_key_q));
    is_second = (event_code_i == 16'(second_key_q));
    is_pass   = (event_type_i != TypeKey) || (!is_first && !is_second);
    val_ok    = (event_value_i[31:1] == 31'd0);
    dev_ok    = (32'(source_device_i) < MaxDevices);
    idx       = DevW'(source_device_i);
    v         = event_value_i[0];
    hf_new    = is_first ? v : first_held_q[idx];
    hs_new    = is_first ? second_held_q[idx] : v;
    n         = 2'(hf_new) + 2'(hs_new) + 2'(v);
    act       = active_q[idx];
    up        = act ? first_virt_q : second_virt_q;
    down      = act ? second_virt_q : first_virt_q;
    upd       = !is_scan && !is_pass && val_ok && dev_ok;

    cmd.kind    = CmdPass;
    cmd.ev_type = event_type_i;
    cmd.code    = event_code_i;
    cmd.alt     = down;
    cmd.value   = event_value_i;
    act_new     = act;
    if (!is_pass) begin
      case (n)
        2'd2: begin
          cmd.kind = CmdPress;
          cmd.code = 16'(is_first ? first_virt_q : second_virt_q);
          act_new  = is_first;
        end
        2'd1, 2'd3: begin
          cmd.kind = CmdSwap;
          cmd.code = 16'(up);
          act_new  = !act;
        end
        default: begin
          cmd.kind = CmdRelease;
          cmd.code = 16'(up);
          act_new  = 1'b0;
        end
      endcase
    end

    push_o.valid = accept_i && !is_scan && (is_pass || upd);
    push_o.cmd   = cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_held_q  <= '0;
      second_held_q <= '0;
      active_q      <= '0;
    end else if (accept_i && upd) begin
      first_held_q[idx]  <= hf_new;
      second_held_q[idx] <= hs_new;
      active_q[idx]      <= act_new;
    end
  end

endmodule

// ----- design/socd_ttf_fifo.sv -----
// Command queue between front and back end.
// Depends on socd_ttf_pkg and the assertion macro header.
`include "socd_two_key_toggle_filter_core_assert.svh"
module socd_ttf_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  socd_ttf_pkg::q_push_t push_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic                  head_valid_o,
  output socd_ttf_pkg::cmd_t    head_o
);
  import socd_ttf_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == QCntW'(QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i.valid ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCntW'(push_i.valid) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.cmd;
    end
  end

  `SOCD_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, push_i.valid, !full_o, "push into full queue")
  `SOCD_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, pop_i, head_valid_o, "pop from empty queue")
  `SOCD_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= QCntW'(QDepth), "count overflow")

endmodule

// ----- design/socd_ttf_back.sv -----
// Back end: expands queued commands, one result event per unstalled cycle,
// into an output register. Depends on socd_ttf_pkg and the assertion header.
`include "socd_two_key_toggle_filter_core_assert.svh"
module socd_ttf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  socd_ttf_pkg::cmd_t  head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         out_type_o,
  output logic [15:0]         out_code_o,
  output logic signed [31:0]  out_value_o,
  output logic                click_o,
  output logic                last_o
);
  import socd_ttf_pkg::*;

  logic [1:0]  step_q, step_d, last_step;
  logic        load, is_last;
  logic        valid_q, valid_d;
  logic [15:0] type_q, type_d, code_q, code_d;
  logic [31:0] value_q, value_d;
  logic        click_q, click_d, last_q, last_d;

  always_comb begin
    case (head_i.kind)
      CmdPass: last_step = 2'd0;
      CmdSwap: last_step = 2'd3;
      default: last_step = 2'd1;
    endcase
    load    = head_valid_i && (!valid_q || !out_stall_i);
    is_last = (step_q == last_step);
    pop_o   = load && is_last;
    step_d  = load ? (is_last ? 2'd0 : step_q + 2'd1) : step_q;
    valid_d = load || (valid_q && out_stall_i);

    click_d = (head_i.kind == CmdPress) || (head_i.kind == CmdSwap);
    last_d  = is_last;
    if (head_i.kind == CmdPass) begin
      type_d  = head_i.ev_type;
      code_d  = head_i.code;
      value_d = head_i.value;
    end else if (step_q[0]) begin
      type_d  = TypeSync;
      code_d  = '0;
      value_d = '0;
    end else begin
      type_d  = TypeKey;
      code_d  = step_q[1] ? 16'(head_i.alt) : head_i.code;
      value_d = (head_i.kind == CmdSwap) ? 32'(step_q[1]) : 32'(head_i.kind == CmdPress);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      type_q  <= type_d;
      code_q  <= code_d;
      value_q <= value_d;
      click_q <= click_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_type_o  = type_q;
  assign out_code_o  = code_q;
  assign out_value_o = $signed(value_q);
  assign click_o     = click_q;
  assign last_o      = last_q;

  `SOCD_ASSERT_NXT(a_step_clear, clk_i, rst_ni, pop_o, step_q == 2'd0, "step not cleared after pop")
  `SOCD_ASSERT_IMP(a_pass_single, clk_i, rst_ni, head_valid_i && head_i.kind == CmdPass, step_q == 2'd0, "pass command past first step")
  `SOCD_ASSERT_NXT(a_odd_sync, clk_i, rst_ni, load && step_q[0], out_type_o == TypeSync, "odd step is not a sync")

endmodule

// ----- design/socd_two_key_toggle_filter_core.sv -----
// Top level of the SOCD two-key toggle filter.
// Depends on socd_ttf_pkg, socd_ttf_front, socd_ttf_fifo and socd_ttf_back.
//
// Input channel: in_valid_i / in_stall_o with the event fields; a transfer
// happens at a clock edge with valid high and stall low. Output channel:
// out_valid_o / out_stall_i with one result event per transfer; last_o marks
// the final result of an input event, click_o marks results of inputs that
// caused a virtual press. Configuration: cfg_we_i writes cfg_wdata_i into the
// register selected by cfg_index_i (first key, second key, first virtual,
// second virtual); the user must write only while the block is idle, which
// the block does not enforce. An accepted event goes through the command
// queue into the output register; the back end issues one result per cycle
// while out_stall_i is low: one per pass, two per press or last release,
// four per swap, none per dropped event. The four-entry queue lets the front
// take events while the back end drains; in_stall_o rises only when that
// queue is full. Reset clears all held/active flags and loads the default
// key codes. While out_stall_i is high the output register holds its result.
module socd_two_key_toggle_filter_core #(
  parameter int unsigned MaxDevices = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [9:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         source_device_i,
  input  logic [15:0]        event_type_i,
  input  logic [15:0]        event_code_i,
  input  logic signed [31:0] event_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        out_type_o,
  output logic [15:0]        out_code_o,
  output logic signed [31:0] out_value_o,
  output logic               click_o,
  output logic               last_o
);
  import socd_ttf_pkg::*;

  q_push_t push;
  logic    full, head_valid, pop, accept;
  cmd_t    head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  socd_ttf_front #(
    .MaxDevices(MaxDevices)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .accept_i        (accept),
    .source_device_i (source_device_i),
    .event_type_i    (event_type_i),
    .event_code_i    (event_code_i),
    .event_value_i   (event_value_i),
    .push_o          (push)
  );

  socd_ttf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  socd_ttf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_type_o   (out_type_o),
    .out_code_o   (out_code_o),
    .out_value_o  (out_value_o),
    .click_o      (click_o),
    .last_o       (last_o)
  );

endmodule
